// ----- hdl/mco_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mco_pkg
// Shared types and constants of the midpoint circle outline rasterizer.
// ----------------------------------------------------------------------------
package mco_pkg;

  localparam int COORD_BITS  = 12;
  localparam int QUEUE_DEPTH = 2;
  localparam int NUM_POINTS  = 8;
  localparam int PT_IDX_BITS = $clog2(NUM_POINTS);
  localparam int CFG_IDX_BITS = 2;

  // per octant point: bit k set means the coordinate is mirrored (c - a - 1)
  localparam logic [NUM_POINTS-1:0] X_NEG = 8'b1110_0100;
  localparam logic [NUM_POINTS-1:0] Y_NEG = 8'b1101_1000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic live;  // point set to emit, else one idle marker
    logic fin;   // outline done after this step
  } step_flags_t;

endpackage

// ----- hdl/mco_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mco_front
// Configuration registers and octant walk: classifies each step, advances
// the midpoint error and hands the current point to the step queue.
// ----------------------------------------------------------------------------
module mco_front #(
  parameter int COORD_BITS = mco_pkg::COORD_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [mco_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0]          cfg_data_i,
  input  logic                           step_i,
  input  logic                           restart_i,
  output mco_pkg::step_flags_t           flags_o,
  output logic signed [COORD_BITS-1:0]   u_o,
  output logic signed [COORD_BITS-1:0]   v_o,
  output logic [COORD_BITS-1:0]          cx_o,
  output logic [COORD_BITS-1:0]          cy_o
);

  localparam int EB = COORD_BITS + 2;

  logic [COORD_BITS-1:0] cx_q, cy_q;
  logic [COORD_BITS-2:0] radius_q;
  logic signed [COORD_BITS-1:0] u_q, v_q, u_d, v_d;
  logic signed [EB-1:0] err_q, err_d;
  logic running_q, running_d;

  logic signed [COORD_BITS-1:0] u0, v0, u1, v1;
  logic signed [EB-1:0] err0, err_a, err_b;
  logic run0, run1, adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      radius_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mco_pkg::CFG_CENTER_X: cx_q <= cfg_data_i;
        mco_pkg::CFG_CENTER_Y: cy_q <= cfg_data_i;
        mco_pkg::CFG_RADIUS:   radius_q <= cfg_data_i[COORD_BITS-2:0];
        default: ;
      endcase
    end
  end

  // state seen by this step, reloaded from the radius on restart
  always_comb begin
    if (restart_i) begin
      u0   = $signed({1'b0, radius_q}) - $signed(COORD_BITS'(1));
      v0   = '0;
      err0 = $signed(EB'(0) - EB'(radius_q));
      run0 = (radius_q != '0);
    end else begin
      u0   = u_q;
      v0   = v_q;
      err0 = err_q;
      run0 = running_q;
    end
  end

  // midpoint update, both outcomes in parallel
  always_comb begin
    err_a = err0 + (EB'(v0) <<< 1) + EB'(2);
    err_b = err_a - (EB'(u0) <<< 1) + EB'(1);
    adv   = !err_a[EB-1];
    v1    = v0 + COORD_BITS'(1);
    u1    = adv ? (u0 - COORD_BITS'(1)) : u0;
    run1  = (u1 >= v1);
  end

  always_comb begin
    u_d       = run0 ? u1 : u0;
    v_d       = run0 ? v1 : v0;
    err_d     = run0 ? (adv ? err_b : err_a) : err0;
    running_d = run0 ? run1 : run0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q       <= '0;
      v_q       <= '0;
      err_q     <= '0;
      running_q <= 1'b0;
    end else if (step_i) begin
      u_q       <= u_d;
      v_q       <= v_d;
      err_q     <= err_d;
      running_q <= running_d;
    end
  end

  assign flags_o.live = run0;
  assign flags_o.fin  = run0 ? !run1 : 1'b1;
  assign u_o  = u0;
  assign v_o  = v0;
  assign cx_o = cx_q;
  assign cy_o = cy_q;

endmodule

// ----- hdl/mco_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mco_queue
// Small first-in first-out step queue between the walk and the emitter.
// ----------------------------------------------------------------------------
module mco_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mco_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] entries_q [DEPTH];
  logic [AW:0] wr_ptr_q, rd_ptr_q;

  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign full_o  = (wr_ptr_q[AW] != rd_ptr_q[AW]) && (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
  assign data_o  = entries_q[rd_ptr_q[AW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q[AW-1:0]] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + (AW+1)'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + (AW+1)'(1);
      end
    end
  end

endmodule

// ----- hdl/mco_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mco_back
// Point emitter: turns each queued step into its eight mirrored pixels (an
// idle step: one marker), one per cycle unless stalled, into output registers.
// ----------------------------------------------------------------------------
module mco_back #(
  parameter int COORD_BITS = mco_pkg::COORD_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           head_valid_i,
  input  mco_pkg::step_flags_t           head_flags_i,
  input  logic signed [COORD_BITS-1:0]   head_u_i,
  input  logic signed [COORD_BITS-1:0]   head_v_i,
  input  logic [COORD_BITS-1:0]          head_cx_i,
  input  logic [COORD_BITS-1:0]          head_cy_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [COORD_BITS+1:0]   pixel_x_o,
  output logic signed [COORD_BITS+1:0]   pixel_y_o,
  output logic                           point_valid_o,
  output logic                           last_of_step_o,
  output logic                           finished_o
);

  localparam int PW = COORD_BITS + 2;
  localparam int KB = mco_pkg::PT_IDX_BITS;

  logic [KB-1:0] k_q, k_d;
  logic out_valid_q, out_valid_d;
  logic signed [PW-1:0] x_q, y_q, x_d, y_d;
  logic pv_q, last_q, fin_q;

  logic load, last_now;
  logic signed [COORD_BITS-1:0] ax, ay;
  logic signed [PW-1:0] ax_ext, ay_ext;

  assign load     = head_valid_i && (!out_valid_q || out_ready_i);
  assign last_now = !head_flags_i.live || (k_q == KB'(mco_pkg::NUM_POINTS - 1));
  assign pop_o    = load && last_now;

  // even points take u on x, odd points take v on x
  always_comb begin
    ax     = k_q[0] ? head_v_i : head_u_i;
    ay     = k_q[0] ? head_u_i : head_v_i;
    ax_ext = PW'(ax);
    ay_ext = PW'(ay);
    if (head_flags_i.live) begin
      x_d = $signed(PW'(head_cx_i)) + (mco_pkg::X_NEG[k_q] ? ~ax_ext : ax_ext);
      y_d = $signed(PW'(head_cy_i)) + (mco_pkg::Y_NEG[k_q] ? ~ay_ext : ay_ext);
    end else begin
      x_d = '0;
      y_d = '0;
    end
  end

  always_comb begin
    k_d = k_q;
    if (load) begin
      k_d = last_now ? '0 : k_q + KB'(1);
    end
    out_valid_d = load ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q    <= x_d;
      y_q    <= y_d;
      pv_q   <= head_flags_i.live;
      last_q <= last_now;
      fin_q  <= head_flags_i.fin && last_now;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = x_q;
  assign pixel_y_o      = y_q;
  assign point_valid_o  = pv_q;
  assign last_of_step_o = last_q;
  assign finished_o     = fin_q;

  // a step in progress keeps its queue entry until its last point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_q != '0) |-> head_valid_i && head_flags_i.live)
    else $error("point index advanced without a live step at the queue head");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q) |-> pv_q)
    else $error("non-final result without a point");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && fin_q) |-> last_q)
    else $error("finished flag on a non-final result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pv_q) |-> (x_q == '0) && (y_q == '0) && last_q)
    else $error("idle marker carries coordinates");

endmodule

// ----- hdl/midpoint_circle_outline.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_outline
// Midpoint circle rasterizer: each running step transfer yields the eight octant
// mirrored pixels of the current point and advances the walk.
//
//   channel   direction  handshake               payload
//   in        sink       in_valid_i / in_ready_o   restart_i
//   out       source     out_valid_o / out_ready_i pixel_x/y, point_valid, last_of_step,
//                                                  finished
//   cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// a running step gives eight results one after another, an idle step one
// result; the single-port point emitter sets this pace, and out_ready_i can stall it
// the walk advances in the cycle a step is transferred in; the step queue
// lets further steps enter while the emitter is still busy or stalled
// the first result is written to the output registers after the step has passed the step queue
// reset clears the walk, the queue and the output stage; no clearing pass
// ----------------------------------------------------------------------------
module midpoint_circle_outline #(
  parameter int COORD_BITS = mco_pkg::COORD_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             restart_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [COORD_BITS+1:0]     pixel_x_o,
  output logic signed [COORD_BITS+1:0]     pixel_y_o,
  output logic                             point_valid_o,
  output logic                             last_of_step_o,
  output logic                             finished_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mco_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0]            cfg_data_i
);

  localparam int QW = 2 + 4 * COORD_BITS;

  logic step;
  logic q_full, q_empty, q_pop;
  logic [QW-1:0] q_wdata, q_rdata;

  mco_pkg::step_flags_t f_flags, h_flags;
  logic signed [COORD_BITS-1:0] f_u, f_v, h_u, h_v;
  logic [COORD_BITS-1:0] f_cx, f_cy, h_cx, h_cy;

  assign in_ready_o  = !q_full;
  assign cfg_ready_o = 1'b1;
  assign step        = in_valid_i && !q_full;

  mco_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .restart_i  (restart_i),
    .flags_o    (f_flags),
    .u_o        (f_u),
    .v_o        (f_v),
    .cx_o       (f_cx),
    .cy_o       (f_cy)
  );

  assign q_wdata = {f_flags, f_u, f_v, f_cx, f_cy};
  assign {h_flags, h_u, h_v, h_cx, h_cy} = q_rdata;

  mco_queue #(
    .WIDTH(QW),
    .DEPTH(mco_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (step),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  mco_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (!q_empty),
    .head_flags_i  (h_flags),
    .head_u_i      (h_u),
    .head_v_i      (h_v),
    .head_cx_i     (h_cx),
    .head_cy_i     (h_cy),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .point_valid_o (point_valid_o),
    .last_of_step_o(last_of_step_o),
    .finished_o    (finished_o)
  );

endmodule

// ----- sim/tb_midpoint_circle_outline.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midpoint_circle_outline
// Self-checking bench for the midpoint circle rasterizer. A behavioral octant
// walk predicts the eight mirrored pixels, or the idle marker, for every
// accepted step. Each output transfer is checked against the oldest predicted
// pixel. Directed tests cover idle steps, register extremes and masking,
// tiny radii and live register updates. A long receiver hold-off fills the
// block. Random episodes then draw outlines, whole for small radii, partial
// for large ones, under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_midpoint_circle_outline;

  localparam int CW = mco_pkg::COORD_BITS;
  localparam int PW = mco_pkg::COORD_BITS + 2;
  localparam int IW = mco_pkg::CFG_IDX_BITS;
  localparam logic [IW-1:0] CFG_UNUSED = 2'd3;
  localparam int RAND_STEPS    = 375;
  localparam int SMALL_R_MAX   = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS   = 10;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic                 live;
    logic                 last;
    logic                 done;
  } pixel_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic                    restart_i   = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [PW-1:0]    pixel_x_o;
  logic signed [PW-1:0]    pixel_y_o;
  logic                    point_valid_o;
  logic                    last_of_step_o;
  logic                    finished_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [IW-1:0]           cfg_index_i = mco_pkg::CFG_CENTER_X;
  logic [CW-1:0]           cfg_data_i  = '0;

  // predicted pixels still owed by the block
  pixel_t pending_pixels[$];

  // shadow registers and walk state
  logic [CW-1:0] ctr_x = '0;
  logic [CW-1:0] ctr_y = '0;
  logic [CW-2:0] rad   = '0;
  int walk_u   = 0;
  int walk_v   = 0;
  int walk_err = 0;
  bit walk_on  = 1'b0;

  int n_steps       = 0;
  int n_idle_marks  = 0;
  int n_pixels      = 0;
  int n_outlines    = 0;
  int n_fails       = 0;
  int n_episodes    = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_token    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  midpoint_circle_outline uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .point_valid_o  (point_valid_o),
    .last_of_step_o (last_of_step_o),
    .finished_o     (finished_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // octant walk for one accepted step
  function automatic void plot_step(input bit restart);
    int xs[mco_pkg::NUM_POINTS];
    int ys[mco_pkg::NUM_POINTS];
    int cx;
    int cy;
    int u;
    int v;
    pixel_t p;
    cx = int'(ctr_x);
    cy = int'(ctr_y);
    n_steps++;
    if (restart) begin
      walk_u   = int'(rad) - 1;
      walk_v   = 0;
      walk_err = -int'(rad);
      walk_on  = (walk_u >= walk_v);
    end
    if (!walk_on) begin
      p = '{px: '0, py: '0, live: 1'b0, last: 1'b1, done: 1'b1};
      pending_pixels.push_back(p);
      n_idle_marks++;
      return;
    end
    u = walk_u;
    v = walk_v;
    xs[0] = cx + u;     ys[0] = cy + v;
    xs[1] = cx + v;     ys[1] = cy + u;
    xs[2] = cx - u - 1; ys[2] = cy + v;
    xs[3] = cx + v;     ys[3] = cy - u - 1;
    xs[4] = cx + u;     ys[4] = cy - v - 1;
    xs[5] = cx - v - 1; ys[5] = cy + u;
    xs[6] = cx - u - 1; ys[6] = cy - v - 1;
    xs[7] = cx - v - 1; ys[7] = cy - u - 1;
    walk_err += 2 * v + 2;
    v++;
    if (walk_err >= 0) begin
      u--;
      walk_err -= 2 * u + 1;
    end
    walk_u  = u;
    walk_v  = v;
    walk_on = (u >= v);
    for (int k = 0; k < mco_pkg::NUM_POINTS; k++) begin
      p.px   = PW'(xs[k]);
      p.py   = PW'(ys[k]);
      p.live = 1'b1;
      p.last = (k == mco_pkg::NUM_POINTS - 1);
      p.done = (k == mco_pkg::NUM_POINTS - 1) && !walk_on;
      pending_pixels.push_back(p);
    end
  endfunction

  function automatic void note_mismatch(input string what, input pixel_t want,
                                        input pixel_t got);
    n_fails++;
    if (n_fails <= MAX_REPORTS)
      $display({"%0t %s: expected x=%0d y=%0d pv=%b last=%b fin=%b,",
                " got x=%0d y=%0d pv=%b last=%b fin=%b"},
               $time, what, want.px, want.py, want.live, want.last, want.done,
               got.px, got.py, got.live, got.last, got.done);
  endfunction

  always @(posedge clk_i) begin : check_pixels
    pixel_t got;
    pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{pixel_x_o, pixel_y_o, point_valid_o, last_of_step_o, finished_o};
      if (pending_pixels.size() == 0) begin
        note_mismatch("pixel with no step pending", '0, got);
      end else begin
        want = pending_pixels.pop_front();
        if (got.px !== want.px || got.py !== want.py || got.live !== want.live ||
            got.last !== want.last || got.done !== want.done)
          note_mismatch("pixel mismatch", want, got);
        else if (want.live) begin
          n_pixels++;
          if (want.done) n_outlines++;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin : drive_ready
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 70; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 70; end
      default:       begin send_idle_pct = 25; recv_stall_pct = 25; end
    endcase
  endtask

  task automatic send_step(input bit restart);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'($urandom_range(1));
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    plot_step(restart);
  endtask

  // stop offering steps and let every owed pixel drain
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      mco_pkg::CFG_CENTER_X: ctr_x = data;
      mco_pkg::CFG_CENTER_Y: ctr_y = data;
      mco_pkg::CFG_RADIUS:   rad   = data[CW-2:0];
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic update_reg(input logic [IW-1:0] idx, input logic [CW-1:0] data);
    wait_idle();
    write_reg(idx, data);
    cfg_release();
  endtask

  task automatic configure(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                           input logic [CW-1:0] rdata);
    wait_idle();
    write_reg(mco_pkg::CFG_CENTER_X, cx);
    write_reg(mco_pkg::CFG_CENTER_Y, cy);
    write_reg(mco_pkg::CFG_RADIUS, rdata);
    cfg_release();
  endtask

  // walk until the outline closes or the step budget runs out, then send tail steps
  task automatic run_outline(input bit first_restart, input int max_steps,
                             input int tail_steps, input bit noisy);
    int k;
    send_step(first_restart);
    k = 1;
    while (walk_on && k < max_steps) begin
      send_step(noisy && ($urandom_range(11) == 0));
      k++;
    end
    repeat (tail_steps) send_step(1'b0);
  endtask

  task automatic test_idle_steps();
    set_idling(IDLE_NONE);
    send_step(1'b0);
    send_step(1'b1);
  endtask

  task automatic test_register_extremes();
    set_idling(IDLE_NONE);
    wait_idle();
    write_reg(CFG_UNUSED, '1);
    write_reg(mco_pkg::CFG_CENTER_X, '1);
    write_reg(mco_pkg::CFG_CENTER_Y, '1);
    write_reg(mco_pkg::CFG_RADIUS, '1);
    cfg_release();
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    configure('0, '0, 12'h7ff);
    update_reg(CFG_UNUSED, '0);
    send_step(1'b1);
    send_step(1'b0);
  endtask

  task automatic test_tiny_circles();
    set_idling(IDLE_BOTH);
    // upper radius bit is dropped
    configure(12'd100, 12'd200, 12'h801);
    run_outline(1'b1, 4, 1, 1'b0);
    configure(12'd100, 12'd200, 12'd2);
    run_outline(1'b1, 4, 1, 1'b0);
    configure(12'd7, 12'd3, 12'd3);
    run_outline(1'b1, 4, 0, 1'b0);
  endtask

  task automatic test_live_registers();
    set_idling(IDLE_RECEIVER);
    configure(12'd2000, 12'd1500, 12'd9);
    send_step(1'b1);
    send_step(1'b0);
    // center is used at once, radius only after a restart
    wait_idle();
    write_reg(mco_pkg::CFG_CENTER_X, 12'd30);
    write_reg(mco_pkg::CFG_CENTER_Y, 12'd4000);
    cfg_release();
    send_step(1'b0);
    update_reg(mco_pkg::CFG_RADIUS, 12'd5);
    send_step(1'b0);
    send_step(1'b1);
  endtask

  task automatic test_stalled_output();
    set_idling(IDLE_NONE);
    configure(CW'($urandom_range(4095)), CW'($urandom_range(4095)), 12'd60);
    hold_token++;
    run_outline(1'b1, 24, 0, 1'b0);
  endtask

  task automatic test_random_outlines();
    int first;
    int r;
    bit big;
    first = n_steps;
    while (n_steps - first < RAND_STEPS) begin
      big = ($urandom_range(7) == 0);
      r = big ? $urandom_range(SMALL_R_MAX + 1, 2047) : $urandom_range(0, SMALL_R_MAX);
      configure(CW'($urandom_range(4095)), CW'($urandom_range(4095)),
                {1'($urandom_range(1)), 11'(r)});
      set_idling(idle_mode_e'(n_episodes % 4));
      if (big)
        run_outline(1'b1, $urandom_range(4, 12), 0, 1'b1);
      else
        run_outline($urandom_range(9) != 0, 2 * SMALL_R_MAX, $urandom_range(2), 1'b1);
      n_episodes++;
    end
  endtask

  initial begin
    set_idling(IDLE_NONE);
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_idle_steps();
    test_register_extremes();
    test_tiny_circles();
    test_live_registers();
    test_stalled_output();
    test_random_outlines();
    wait_idle();
    $display("run: %0d steps, %0d pixels plotted, %0d idle markers, %0d outlines closed",
             n_steps, n_pixels, n_idle_marks, n_outlines);
    $display("run: %0d random circle episodes under four idling patterns, %0d mismatches",
             n_episodes, n_fails);
    if (n_fails == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d pixels still owed", pending_pixels.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
